// File: rtl/x86dec_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// x86dec_pkg
// Codes, opcode patterns and stage records for the 16-bit x86 decoder of the
// mov/add/sub/cmp subset.
// ----------------------------------------------------------------------------
package x86dec_pkg;

    // Operation codes of a result word
    typedef enum logic [1:0] {
        OPER_MOV = 2'd0,
        OPER_ADD = 2'd1,
        OPER_SUB = 2'd2,
        OPER_CMP = 2'd3
    } oper_t;

    // Instruction forms; the two unused codes never leave the decoder
    typedef enum logic [2:0] {
        FORM_RM_REG  = 3'd0,
        FORM_IMM_REG = 3'd1,
        FORM_IMM_RM  = 3'd2,
        FORM_MEM_ACC = 3'd3,
        FORM_ACC_MEM = 3'd4,
        FORM_IMM_ACC = 3'd5
    } form_t;

    // Opcode patterns, matched on opcode[7:2]
    localparam logic [5:0] OPC6_MOV_RM = 6'h22;
    localparam logic [5:0] OPC6_ADD_RM = 6'h00;
    localparam logic [5:0] OPC6_SUB_RM = 6'h0A;
    localparam logic [5:0] OPC6_CMP_RM = 6'h0E;
    localparam logic [5:0] OPC6_GRP1   = 6'h20;
    // Matched on opcode[7:4]
    localparam logic [3:0] OPC4_MOV_IMM_REG = 4'hB;
    // Matched on opcode[7:1]
    localparam logic [6:0] OPC7_MOV_IMM_RM  = 7'h63;
    localparam logic [6:0] OPC7_MOV_MEM_ACC = 7'h50;
    localparam logic [6:0] OPC7_MOV_ACC_MEM = 7'h51;
    localparam logic [6:0] OPC7_ADD_IMM_ACC = 7'h02;
    localparam logic [6:0] OPC7_SUB_IMM_ACC = 7'h16;
    localparam logic [6:0] OPC7_CMP_IMM_ACC = 7'h1E;

    // Group-1 sub-operations in the reg field
    localparam logic [2:0] SUB_ADD = 3'd0;
    localparam logic [2:0] SUB_SUB = 3'd5;
    localparam logic [2:0] SUB_CMP = 3'd7;

    // Mod field values and the rm code that means a direct address
    localparam logic [1:0] MOD_NO_DISP   = 2'd0;
    localparam logic [1:0] MOD_DISP8     = 2'd1;
    localparam logic [1:0] MOD_DISP16    = 2'd2;
    localparam logic [2:0] RM_DIRECT     = 3'd6;

    // Byte positions inside the window
    localparam logic [2:0] POS_AFTER_MODRM = 3'd2;
    localparam logic [2:0] POS_AFTER_D8    = 3'd3;
    localparam logic [2:0] POS_AFTER_D16   = 3'd4;

    // Window bytes 1..5 kept as entries 0..4
    typedef logic [4:0][7:0] win_t;

    // Opcode class, first stage
    typedef struct packed {
        oper_t       operation;
        form_t       form;
        logic        wide;
        logic        to_register;
        logic [2:0]  reg_index;
        logic        sign_ext;
        logic        invalid;
    } cls_t;

    // Operand addressing, second stage
    typedef struct packed {
        cls_t        cls;
        logic [1:0]  mode;
        logic [2:0]  rm_index;
        logic        direct_address;
        logic [15:0] displacement;
        logic [2:0]  pos;
    } adr_t;

    // Full result word
    typedef struct packed {
        oper_t       operation;
        form_t       form;
        logic        wide;
        logic        to_register;
        logic [1:0]  mode;
        logic [2:0]  reg_index;
        logic [2:0]  rm_index;
        logic        direct_address;
        logic [15:0] displacement;
        logic [15:0] immediate;
        logic [2:0]  length;
        logic        invalid;
    } res_t;

endpackage

// File: rtl/x86_16bit_instruction_decoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// x86_16bit_instruction_decoder_top
// Decodes one mov/add/sub/cmp instruction from a six-byte window per word.
// ----------------------------------------------------------------------------
// The decoder takes one six-byte window per cycle and returns one result word
// through a classify stage for the opcode, an addressing stage for the
// mod-reg-rm byte and displacement, and an immediate/length stage that is
// also the output register. Throughput is one word per clock; a stall on the
// output side holds every full stage in place and the input is taken again as
// soon as the first stage has room. Unknown opcodes and sub-operations come
// out with invalid set, length zero and only the w bit of the opcode in wide.
// ----------------------------------------------------------------------------
module x86_16bit_instruction_decoder_top
    import x86dec_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // Input channel
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         instr_byte0,
    input  logic [7:0]         instr_byte1,
    input  logic [7:0]         instr_byte2,
    input  logic [7:0]         instr_byte3,
    input  logic [7:0]         instr_byte4,
    input  logic [7:0]         instr_byte5,
    // Output channel
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         operation,
    output logic [2:0]         form,
    output logic               wide,
    output logic               to_register,
    output logic [1:0]         mode,
    output logic [2:0]         reg_index,
    output logic [2:0]         rm_index,
    output logic               direct_address,
    output logic signed [15:0] displacement,
    output logic [15:0]        immediate,
    output logic [2:0]         length,
    output logic               invalid
);

    logic  s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic  s1_load, s2_load, s3_load;
    win_t  s1_win_reg, s2_win_reg;
    cls_t  s1_cls_reg, cls_next;
    adr_t  s2_adr_reg, adr_next;
    res_t  s3_res_reg, res_next;
    logic [2:0] sub_op;
    logic [7:0] pos_byte;
    logic [15:0] pos_word;

    // Stage enables: a stage loads when it is empty or its successor moves
    assign s3_load  = !s3_valid_reg || out_ready;
    assign s2_load  = !s2_valid_reg || s3_load;
    assign s1_load  = !s1_valid_reg || s2_load;
    assign in_ready = s1_load;

    // Stage 1: classify the opcode
    assign sub_op = instr_byte1[5:3];

    always_comb
    begin
        cls_next      = '0;
        cls_next.wide = instr_byte0[0];
        priority if (instr_byte0[7:2] == OPC6_MOV_RM || instr_byte0[7:2] == OPC6_ADD_RM
                     || instr_byte0[7:2] == OPC6_SUB_RM || instr_byte0[7:2] == OPC6_CMP_RM)
        begin
            priority if (instr_byte0[7:2] == OPC6_MOV_RM)
                cls_next.operation = OPER_MOV;
            else if (instr_byte0[7:2] == OPC6_ADD_RM)
                cls_next.operation = OPER_ADD;
            else if (instr_byte0[7:2] == OPC6_SUB_RM)
                cls_next.operation = OPER_SUB;
            else
                cls_next.operation = OPER_CMP;
            cls_next.form        = FORM_RM_REG;
            cls_next.to_register = instr_byte0[1];
        end
        else if (instr_byte0[7:4] == OPC4_MOV_IMM_REG)
        begin
            cls_next.operation   = OPER_MOV;
            cls_next.form        = FORM_IMM_REG;
            cls_next.wide        = instr_byte0[3];
            cls_next.to_register = 1'b1;
            cls_next.reg_index   = instr_byte0[2:0];
        end
        else if (instr_byte0[7:1] == OPC7_MOV_IMM_RM)
        begin
            cls_next.operation = OPER_MOV;
            cls_next.form      = FORM_IMM_RM;
            cls_next.invalid   = (sub_op != SUB_ADD);
        end
        else if (instr_byte0[7:2] == OPC6_GRP1)
        begin
            cls_next.form     = FORM_IMM_RM;
            cls_next.sign_ext = instr_byte0[1];
            priority if (sub_op == SUB_ADD)
                cls_next.operation = OPER_ADD;
            else if (sub_op == SUB_SUB)
                cls_next.operation = OPER_SUB;
            else if (sub_op == SUB_CMP)
                cls_next.operation = OPER_CMP;
            else
                cls_next.invalid = 1'b1;
        end
        else if (instr_byte0[7:1] == OPC7_MOV_MEM_ACC || instr_byte0[7:1] == OPC7_MOV_ACC_MEM)
        begin
            cls_next.operation   = OPER_MOV;
            cls_next.form        = (instr_byte0[7:1] == OPC7_MOV_MEM_ACC) ? FORM_MEM_ACC
                                                                          : FORM_ACC_MEM;
            cls_next.to_register = (instr_byte0[7:1] == OPC7_MOV_MEM_ACC);
        end
        else if (instr_byte0[7:1] == OPC7_ADD_IMM_ACC || instr_byte0[7:1] == OPC7_SUB_IMM_ACC
                 || instr_byte0[7:1] == OPC7_CMP_IMM_ACC)
        begin
            priority if (instr_byte0[7:1] == OPC7_ADD_IMM_ACC)
                cls_next.operation = OPER_ADD;
            else if (instr_byte0[7:1] == OPC7_SUB_IMM_ACC)
                cls_next.operation = OPER_SUB;
            else
                cls_next.operation = OPER_CMP;
            cls_next.form        = FORM_IMM_ACC;
            cls_next.to_register = 1'b1;
        end
        else
        begin
            cls_next.invalid = 1'b1;
        end

        // Drop everything but the w bit on an unknown word
        if (cls_next.invalid)
        begin
            cls_next         = '0;
            cls_next.wide    = instr_byte0[0];
            cls_next.invalid = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s1_load)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (s1_load && in_valid)
        begin
            s1_cls_reg <= cls_next;
            s1_win_reg <= {instr_byte5, instr_byte4, instr_byte3, instr_byte2, instr_byte1};
        end
    end

    // Stage 2: mod-reg-rm byte and displacement
    always_comb
    begin
        adr_next     = '0;
        adr_next.cls = s1_cls_reg;
        adr_next.pos = POS_AFTER_MODRM;
        if (!s1_cls_reg.invalid)
        begin
            unique case (s1_cls_reg.form)
                FORM_RM_REG, FORM_IMM_RM:
                begin
                    adr_next.mode          = s1_win_reg[0][7:6];
                    adr_next.cls.reg_index = s1_win_reg[0][5:3];
                    adr_next.rm_index      = s1_win_reg[0][2:0];
                    priority if (adr_next.mode == MOD_NO_DISP && adr_next.rm_index == RM_DIRECT)
                    begin
                        adr_next.direct_address = 1'b1;
                        adr_next.displacement   = {s1_win_reg[2], s1_win_reg[1]};
                        adr_next.pos            = POS_AFTER_D16;
                    end
                    else if (adr_next.mode == MOD_DISP8)
                    begin
                        adr_next.displacement = {{8{s1_win_reg[1][7]}}, s1_win_reg[1]};
                        adr_next.pos          = POS_AFTER_D8;
                    end
                    else if (adr_next.mode == MOD_DISP16)
                    begin
                        adr_next.displacement = {s1_win_reg[2], s1_win_reg[1]};
                        adr_next.pos          = POS_AFTER_D16;
                    end
                    else
                    begin
                        adr_next.pos = POS_AFTER_MODRM;
                    end
                end
                FORM_MEM_ACC, FORM_ACC_MEM:
                begin
                    adr_next.rm_index       = RM_DIRECT;
                    adr_next.direct_address = 1'b1;
                    adr_next.displacement   = {s1_win_reg[1], s1_win_reg[0]};
                end
                default:
                begin
                    adr_next.pos = POS_AFTER_MODRM;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (s2_load)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s2_load && s1_valid_reg)
        begin
            s2_adr_reg <= adr_next;
            s2_win_reg <= s1_win_reg;
        end
    end

    // Stage 3: pick the immediate behind the displacement or the opcode, set the length
    always_comb
    begin
        unique case (s2_adr_reg.pos)
            POS_AFTER_D8:
            begin
                pos_byte = s2_win_reg[2];
                pos_word = {s2_win_reg[3], s2_win_reg[2]};
            end
            POS_AFTER_D16:
            begin
                pos_byte = s2_win_reg[3];
                pos_word = {s2_win_reg[4], s2_win_reg[3]};
            end
            default:
            begin
                pos_byte = s2_win_reg[1];
                pos_word = {s2_win_reg[2], s2_win_reg[1]};
            end
        endcase
    end

    always_comb
    begin
        res_next                = '0;
        res_next.operation      = s2_adr_reg.cls.operation;
        res_next.form           = s2_adr_reg.cls.form;
        res_next.wide           = s2_adr_reg.cls.wide;
        res_next.to_register    = s2_adr_reg.cls.to_register;
        res_next.mode           = s2_adr_reg.mode;
        res_next.reg_index      = s2_adr_reg.cls.reg_index;
        res_next.rm_index       = s2_adr_reg.rm_index;
        res_next.direct_address = s2_adr_reg.direct_address;
        res_next.displacement   = s2_adr_reg.displacement;
        res_next.invalid        = s2_adr_reg.cls.invalid;
        if (!s2_adr_reg.cls.invalid)
        begin
            unique case (s2_adr_reg.cls.form)
                FORM_RM_REG:
                begin
                    res_next.length = s2_adr_reg.pos;
                end
                FORM_IMM_RM:
                begin
                    if (s2_adr_reg.cls.wide && !s2_adr_reg.cls.sign_ext)
                    begin
                        res_next.immediate = pos_word;
                        res_next.length    = 3'(s2_adr_reg.pos + 3'd2);
                    end
                    else
                    begin
                        res_next.immediate = (s2_adr_reg.cls.wide && s2_adr_reg.cls.sign_ext)
                                             ? {{8{pos_byte[7]}}, pos_byte}
                                             : {8'h00, pos_byte};
                        res_next.length    = 3'(s2_adr_reg.pos + 3'd1);
                    end
                end
                FORM_MEM_ACC, FORM_ACC_MEM:
                begin
                    res_next.length = 3'd3;
                end
                FORM_IMM_REG, FORM_IMM_ACC:
                begin
                    res_next.immediate = s2_adr_reg.cls.wide
                                         ? {s2_win_reg[1], s2_win_reg[0]}
                                         : {8'h00, s2_win_reg[0]};
                    res_next.length    = s2_adr_reg.cls.wide ? 3'd3 : 3'd2;
                end
                default:
                begin
                    res_next.length = 3'd0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else if (s3_load)
            s3_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s3_load && s2_valid_reg)
            s3_res_reg <= res_next;
    end

    // Drive the output ports from the result register
    assign out_valid      = s3_valid_reg;
    assign operation      = s3_res_reg.operation;
    assign form           = s3_res_reg.form;
    assign wide           = s3_res_reg.wide;
    assign to_register    = s3_res_reg.to_register;
    assign mode           = s3_res_reg.mode;
    assign reg_index      = s3_res_reg.reg_index;
    assign rm_index       = s3_res_reg.rm_index;
    assign direct_address = s3_res_reg.direct_address;
    assign displacement   = s3_res_reg.displacement;
    assign immediate      = s3_res_reg.immediate;
    assign length         = s3_res_reg.length;
    assign invalid        = s3_res_reg.invalid;

`ifndef SYNTH
    // An invalid word carries no length, displacement or immediate
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && invalid |-> length == 3'd0 && displacement == 16'sd0
                                 && immediate == 16'd0)
        else $error("invalid word carries operand data");

    // A valid word is between two and six bytes long
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !invalid |-> length >= 3'd2 && length <= 3'd6)
        else $error("decoded length out of range");

    // A direct address always comes with mod 0 and rm 6
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && direct_address |-> mode == MOD_NO_DISP && rm_index == RM_DIRECT)
        else $error("direct address with wrong mod/rm");

    // A held middle stage keeps its word while the output stalls
    assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg && !s3_load |=> s2_valid_reg && $stable(s2_adr_reg))
        else $error("middle stage lost a word during a stall");
`endif

endmodule
